>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the local clk, masked while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

>>> rtl/bat_pkg.sv
`default_nettype none

package bat_pkg;

  // default configuration
  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_ITER_DEF  = 16;

  // fixed field widths
  localparam int FIELD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int Z_W     = 32;

  // coordinate prescale and headroom for cordic gain
  localparam int PRESCALE_SHIFT = 24;
  localparam int GUARD_BITS     = 3;
  localparam int SHIFT_W        = 5;

  // command codes
  localparam logic CMD_POSITION = 1'b0;
  localparam logic CMD_QUERY    = 1'b1;

  // angle accumulator constants, one turn = 2^32
  localparam logic [Z_W-1:0] Z_ZERO          = 32'h0000_0000;
  localparam logic [Z_W-1:0] Z_QUARTER       = 32'h4000_0000;
  localparam logic [Z_W-1:0] Z_HALF          = 32'h8000_0000;
  localparam logic [Z_W-1:0] Z_THREE_QUARTER = 32'hC000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [Z_W-1:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // status of the cordic unit
  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

endpackage

`default_nettype wire

>>> rtl/bat_cordic.sv
`default_nettype none
`include "assert_macros.svh"

module bat_cordic import bat_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_WIDTH:0] dx,
  input  logic signed [COORD_WIDTH:0] dy,
  output cordic_stat_t              stat,
  output logic [ANGLE_W-1:0]        angle
);

  localparam int W     = COORD_WIDTH + 1 + PRESCALE_SHIFT + GUARD_BITS;
  localparam int CNT_W = $clog2(ANGLE_ITERATIONS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ANGLE_ITERATIONS - 1);

  logic signed [W-1:0] x_r, x_nxt;
  logic signed [W-1:0] y_r, y_nxt;
  logic [Z_W-1:0]      z_r, z_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;

  logic signed [W-1:0] dx_w, dy_w;
  logic signed [W-1:0] xs, ys;
  logic [SHIFT_W-1:0]  k;

  // prescaled differences and shifted operands
  always_comb begin
    dx_w = W'(dx) <<< PRESCALE_SHIFT;
    dy_w = W'(dy) <<< PRESCALE_SHIFT;
    k    = SHIFT_W'(cnt_r);
    xs   = x_r >>> k;
    ys   = y_r >>> k;
  end

  // load, micro-rotation and iteration count
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      cnt_nxt = '0;
      if (dx == '0) begin
        // vertical vector: quarter or three quarters, no rotation
        z_nxt    = (dy > 0) ? Z_QUARTER : Z_THREE_QUARTER;
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else if (dx[COORD_WIDTH]) begin
        // left half plane: turn by half a turn first
        x_nxt    = -dx_w;
        y_nxt    = -dy_w;
        z_nxt    = Z_HALF;
        run_nxt  = 1'b1;
        done_nxt = 1'b0;
      end else begin
        x_nxt    = dx_w;
        y_nxt    = dy_w;
        z_nxt    = Z_ZERO;
        run_nxt  = 1'b1;
        done_nxt = 1'b0;
      end
    end else if (run_r) begin
      if (!y_r[W-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + ATAN_TABLE[k];
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - ATAN_TABLE[k];
      end
      if (cnt_r == LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // round accumulator to 16 bits of a turn
  assign angle     = z_r[Z_W-1:Z_W-ANGLE_W] + ANGLE_W'(z_r[Z_W-ANGLE_W-1]);
  assign stat.busy = run_r;
  assign stat.done = done_r;

  `ASSERT_NEVER(a_no_restart, start && run_r, "cordic started while rotating")
  `ASSERT_NEVER(a_done_idle, done_r && run_r, "cordic done while still rotating")

endmodule

`default_nettype wire

>>> rtl/bearing_angle_to_target_core.sv
// Bearing to target. A transaction with command 0 stores the body position
// (x, y); a transaction with command 1 carries a goal point and yields one
// result: atan2(goal_y - y, goal_x - x) as an unsigned angle in units of
// 2*pi/65536, counterclockwise from +x. The angle comes from one shared
// CORDIC unit in vectoring mode that does one micro-rotation per cycle. A
// position update leaves the sequencer idle, so in_ready stays high. A query
// holds in_ready low after acceptance until the CORDIC unit has run all
// ANGLE_ITERATIONS micro-rotations, or skips them when the x difference is
// zero; the result then goes to an output register, and a finished query
// waits in ST_RUN only while the previous result has not been taken yet.
// Coordinates are signed with 8 fraction bits, sign-extended from bit
// COORD_WIDTH-1 of the field.
`default_nettype none
`include "assert_macros.svh"

module bearing_angle_to_target_core import bat_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic signed [FIELD_W-1:0] in_x_value,
  input  logic signed [FIELD_W-1:0] in_y_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ANGLE_W-1:0]        out_angle
);

  state_t state_r, state_nxt;

  logic signed [COORD_WIDTH-1:0] pos_x_r, pos_x_nxt;
  logic signed [COORD_WIDTH-1:0] pos_y_r, pos_y_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ANGLE_W-1:0]            out_angle_r, out_angle_nxt;

  logic [Z_W-1:0]                x_ext, y_ext;
  logic signed [COORD_WIDTH-1:0] x_coord, y_coord;
  logic signed [COORD_WIDTH:0]   dx, dy;
  logic                          accept;
  logic                          start;
  cordic_stat_t                  cstat;
  logic [ANGLE_W-1:0]            angle;

  // coordinate decode and difference to stored position
  always_comb begin
    x_ext   = Z_W'($unsigned(in_x_value));
    y_ext   = Z_W'($unsigned(in_y_value));
    x_coord = signed'(x_ext[COORD_WIDTH-1:0]);
    y_coord = signed'(y_ext[COORD_WIDTH-1:0]);
    dx      = (COORD_WIDTH+1)'(x_coord) - (COORD_WIDTH+1)'(pos_x_r);
    dy      = (COORD_WIDTH+1)'(y_coord) - (COORD_WIDTH+1)'(pos_y_r);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign start    = accept && (in_command == CMD_QUERY);

  // shared rotation unit
  bat_cordic #(
    .COORD_WIDTH      (COORD_WIDTH),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .dx    (dx),
    .dy    (dy),
    .stat  (cstat),
    .angle (angle)
  );

  // sequencer, position store and output register
  always_comb begin
    state_nxt     = state_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    out_valid_nxt = out_valid_r;
    out_angle_nxt = out_angle_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_POSITION)) begin
          pos_x_nxt = x_coord;
          pos_y_nxt = y_coord;
        end
        if (start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cstat.done && (!out_valid_r || out_ready)) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = angle;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_angle_r <= out_angle_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

  `ASSERT_CLK(a_query_blocks, start |=> !in_ready, "input still open after query")
  `ASSERT_NEVER(a_run_tracked, (state_r == ST_RUN) && !cstat.busy && !cstat.done, "sequencer waits on idle cordic")

endmodule

`default_nettype wire
